// ===== rtl/a64imm_pkg.sv =====
package a64imm_pkg;

  localparam int REG_W    = 64;   // X register width
  localparam int W_BITS   = 32;   // W register width
  localparam int IMM_BITS = 12;   // add/sub immediate field
  localparam int MAG_W    = 2 * IMM_BITS;
  localparam int LANES    = 6;    // element sizes 2, 4, 8, 16, 32, 64
  localparam int SIZE_W   = 4;

  typedef struct packed {
    logic [REG_W-1:0]  raw_value;
    logic [SIZE_W-1:0] size_bytes;
    logic              is_float;
  } in_word_t;

  typedef struct packed {
    logic             addsub_ok;
    logic             addsub_negate;
    logic [MAG_W-1:0] addsub_magnitude;
    logic             logical_ok;
    logic [REG_W-1:0] widened_value;
    logic             reg_is_64;
  } out_word_t;

endpackage

// ===== rtl/arm64_immediate_encodability_core.sv =====
// A64 immediate encodability check. Each input word carries a constant, its
// size in bytes and a float flag; the result word gives the constant masked
// and zero-extended to W or X width, whether it fits an add/sub immediate
// (directly or negated, with the magnitude) and whether it is a bitmask
// logical immediate. A float type or a size outside 1..8 gives an all-zero
// result. The block is a three-stage pipeline: one word enters per cycle
// while in_stall is low, and each word moves through s1_r, s2_r and s3_r in
// turn, with s3_r driving the result word on the output. Stall propagates
// back stage by stage, so empty stages keep filling while the output waits;
// in_stall is high only when all three stages hold words and the output is
// stalled.
module arm64_immediate_encodability_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  a64imm_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output a64imm_pkg::out_word_t out_word
);
  import a64imm_pkg::*;

  // stage 1: masked value, width select, reject flag
  typedef struct packed {
    logic             rej;
    logic             x64;
    logic [REG_W-1:0] widened;
  } s1_t;

  // stage 2: add/sub result done, logical check half done
  typedef struct packed {
    logic                        rej;
    logic                        x64;
    logic [REG_W-1:0]            widened;
    logic                        ok;
    logic                        neg;
    logic [MAG_W-1:0]            mag;
    logic [LANES-1:0]            per;   // value repeats with this element size
    logic [LANES-1:0][REG_W-1:0] u;     // transitions with lowest one cleared
  } s2_t;

  s1_t       s1_r, s1_nxt;
  s2_t       s2_r, s2_nxt;
  out_word_t s3_r, s3_nxt;
  logic      v1_r, v2_r, v3_r;
  logic      en1, en2, en3;

  // a stage moves when it is empty or the one after it moves
  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // ---------------- stage 1: mask and widen ----------------
  always_comb begin
    s1_nxt.rej = in_word.is_float;
    s1_nxt.x64 = 1'b0;
    unique case (in_word.size_bytes)
      4'd1: s1_nxt.widened = {56'b0, in_word.raw_value[7:0]};
      4'd2: s1_nxt.widened = {48'b0, in_word.raw_value[15:0]};
      4'd3: s1_nxt.widened = {40'b0, in_word.raw_value[23:0]};
      4'd4: s1_nxt.widened = {32'b0, in_word.raw_value[31:0]};
      4'd5: s1_nxt.widened = {24'b0, in_word.raw_value[39:0]};
      4'd6: s1_nxt.widened = {16'b0, in_word.raw_value[47:0]};
      4'd7: s1_nxt.widened = {8'b0, in_word.raw_value[55:0]};
      4'd8: s1_nxt.widened = in_word.raw_value;
      default: begin
        s1_nxt.widened = '0;
        s1_nxt.rej     = 1'b1;
      end
    endcase
    if (in_word.size_bytes > 4'd4) begin
      s1_nxt.x64 = 1'b1;
    end
    if (s1_nxt.rej) begin
      s1_nxt.widened = '0;
      s1_nxt.x64     = 1'b0;
    end
  end

  // ---------------- stage 2: add/sub, periodicity, transitions ----------------
  function automatic logic fits_addsub(input logic [REG_W-1:0] v);
    return (v[REG_W-1:MAG_W] == '0) &&
           ((v[MAG_W-1:IMM_BITS] == '0) || (v[IMM_BITS-1:0] == '0));
  endfunction

  logic [REG_W-1:0]            w;
  logic [REG_W-1:0]            negv;
  logic                        negative, direct, neg_fit;
  logic [LANES-1:0]            per_w, per_x;
  logic [LANES-1:0][REG_W-1:0] t_pad;

  assign w = s1_r.widened;

  for (genvar k = 0; k < LANES; k++) begin : g_elem
    localparam int E = 2 << k;
    logic [E-1:0] elem, tr;
    assign elem = w[E-1:0];
    // cyclic transitions inside the element
    assign tr       = elem ^ {elem[0], elem[E-1:1]};
    assign t_pad[k] = REG_W'(tr);
    if (E < W_BITS) begin : g_wn
      assign per_w[k] = (w[W_BITS-1:0] == {w[E-1:0], w[W_BITS-1:E]});
    end else if (E == W_BITS) begin : g_we
      assign per_w[k] = 1'b1;
    end else begin : g_wx
      assign per_w[k] = 1'b0;
    end
    if (E < REG_W) begin : g_xn
      assign per_x[k] = (w == {w[E-1:0], w[REG_W-1:E]});
    end else begin : g_xe
      assign per_x[k] = 1'b1;
    end
  end

  always_comb begin
    if (s1_r.x64) begin
      // most negative value is never negated
      negative = w[REG_W-1] && (w[REG_W-2:0] != '0);
      negv     = '0 - w;
    end else begin
      negative = w[W_BITS-1];
      negv     = '0 - {{(REG_W-W_BITS){1'b1}}, w[W_BITS-1:0]};
    end
    direct  = fits_addsub(w);
    neg_fit = !direct && negative && fits_addsub(negv);

    s2_nxt.rej     = s1_r.rej;
    s2_nxt.x64     = s1_r.x64;
    s2_nxt.widened = w;
    s2_nxt.ok      = direct || neg_fit;
    s2_nxt.neg     = neg_fit;
    if (direct) begin
      s2_nxt.mag = w[MAG_W-1:0];
    end else if (neg_fit) begin
      s2_nxt.mag = negv[MAG_W-1:0];
    end else begin
      s2_nxt.mag = '0;
    end
    s2_nxt.per = s1_r.x64 ? per_x : per_w;
    for (int k = 0; k < LANES; k++) begin
      s2_nxt.u[k] = t_pad[k] & (t_pad[k] - REG_W'(1));
    end
  end

  // ---------------- stage 3: exactly two transitions, final gating ----------------
  logic [LANES-1:0] two_tr;

  always_comb begin
    // transition count is even, so one bit left after clearing one means two
    for (int k = 0; k < LANES; k++) begin
      two_tr[k] = (s2_r.u[k] != '0) &&
                  ((s2_r.u[k] & (s2_r.u[k] - REG_W'(1))) == '0);
    end
    s3_nxt.addsub_ok        = s2_r.ok && !s2_r.rej;
    s3_nxt.addsub_negate    = s2_r.neg && !s2_r.rej;
    s3_nxt.addsub_magnitude = s2_r.rej ? '0 : s2_r.mag;
    s3_nxt.logical_ok       = (|(s2_r.per & two_tr)) && !s2_r.rej;
    s3_nxt.widened_value    = s2_r.widened;
    s3_nxt.reg_is_64        = s2_r.x64;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) s3_r <= s3_nxt;
  end

  assign out_valid = v3_r;
  assign out_word  = s3_r;

endmodule

// ===== rtl/a64imm_checker.sv =====
module a64imm_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input a64imm_pkg::in_word_t  in_word,
  input logic                  out_valid,
  input logic                  out_stall,
  input a64imm_pkg::out_word_t out_word
);
  import a64imm_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // an output that can drain never backs up the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled with free pipeline");

  a_negate_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.addsub_negate |->
      out_word.addsub_ok && (out_word.addsub_magnitude != '0))
    else $error("negated form without valid encoding");

  a_w_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.reg_is_64 |->
      (out_word.widened_value[REG_W-1:W_BITS] == '0))
    else $error("W result has upper bits set");

  // in_valid and in_word are part of the port view only
  logic unused_in;
  assign unused_in = in_valid ^ (^in_word);

endmodule

bind arm64_immediate_encodability_core a64imm_checker u_a64imm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== verif/arm64_immediate_encodability_checker.sv =====
// Watches both channels of the immediate encodability core, predicts each
// result word from the accepted input word and compares field by field.
module arm64_immediate_encodability_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  a64imm_pkg::in_word_t  in_word,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  a64imm_pkg::out_word_t out_word,
  output int                    fail_count,
  output int                    waiting,
  output int                    results_seen,
  output int                    negated_seen,
  output int                    logical_seen
);
  import a64imm_pkg::*;

  localparam int PRINT_CAP = 40;

  out_word_t encoding_q[$];

  function automatic logic fits_imm12(logic [REG_W-1:0] v);
    return (v <= 64'hfff) || (v[IMM_BITS-1:0] == '0 && (v >> IMM_BITS) <= 64'hfff);
  endfunction

  // rotated run of ones in a replicated power-of-two element
  function automatic logic is_bitmask_imm(logic [REG_W-1:0] value, int width);
    logic [REG_W-1:0] wmask, emask, elem, rep, x;
    logic hit;
    wmask = (width == REG_W) ? '1 : 64'hffff_ffff;
    value = value & wmask;
    hit = 1'b0;
    if (value == '0 || value == wmask) return 1'b0;
    for (int e = 2; e <= width; e = e * 2) begin
      emask = (e == REG_W) ? '1 : ((64'd1 << e) - 64'd1);
      elem  = value & emask;
      rep   = '0;
      for (int off = 0; off < width; off += e) rep = rep | (elem << off);
      if (rep == value && elem != '0 && elem != emask) begin
        for (int r = 0; r < e; r++) begin
          x = (r == 0) ? elem : (((elem >> r) | (elem << (e - r))) & emask);
          if ((x & (x + 64'd1)) == '0) hit = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  function automatic out_word_t predict_encoding(in_word_t w);
    out_word_t        r;
    logic [REG_W-1:0] wide, negv, mag;
    logic             x64, negative;
    int unsigned      sz;
    r  = '0;
    sz = 32'(w.size_bytes);
    if (sz == 0 || sz > 8 || w.is_float) return r;
    x64  = (sz > 4);
    wide = (sz >= 8) ? w.raw_value : (w.raw_value & ((64'd1 << (sz * 8)) - 64'd1));
    mag  = '0;
    if (fits_imm12(wide) && (!x64 || !wide[REG_W-1])) begin
      r.addsub_ok = 1'b1;
      mag = wide;
    end else begin
      if (x64) begin
        negative = wide[REG_W-1] && (wide != 64'h8000_0000_0000_0000);
        negv     = 64'd0 - wide;
      end else begin
        negative = wide[W_BITS-1];
        negv     = 64'd0 - (wide | 64'hffff_ffff_0000_0000);
      end
      if (negative && fits_imm12(negv)) begin
        r.addsub_ok     = 1'b1;
        r.addsub_negate = 1'b1;
        mag = negv;
      end
    end
    r.addsub_magnitude = mag[MAG_W-1:0];
    r.logical_ok       = is_bitmask_imm(wide, x64 ? REG_W : W_BITS);
    r.widened_value    = wide;
    r.reg_is_64        = x64;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [REG_W-1:0] got,
                                 logic [REG_W-1:0] want);
    if (fail_count < PRINT_CAP)
      $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h",
               results_seen, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      encoding_q.delete();
      fail_count = 0;
      waiting      <= 0;
      results_seen <= 0;
      negated_seen <= 0;
      logical_seen <= 0;
    end else begin
      if (in_valid && !in_stall) encoding_q.push_back(predict_encoding(in_word));
      if (out_valid && !out_stall) begin
        if (encoding_q.size() == 0) begin
          report_mismatch("unexpected word", out_word.widened_value, '0);
        end else begin
          want = encoding_q.pop_front();
          if (out_word.addsub_ok !== want.addsub_ok)
            report_mismatch("addsub_ok", REG_W'(out_word.addsub_ok),
                            REG_W'(want.addsub_ok));
          if (out_word.addsub_negate !== want.addsub_negate)
            report_mismatch("addsub_negate", REG_W'(out_word.addsub_negate),
                            REG_W'(want.addsub_negate));
          if (out_word.addsub_magnitude !== want.addsub_magnitude)
            report_mismatch("addsub_magnitude", REG_W'(out_word.addsub_magnitude),
                            REG_W'(want.addsub_magnitude));
          if (out_word.logical_ok !== want.logical_ok)
            report_mismatch("logical_ok", REG_W'(out_word.logical_ok),
                            REG_W'(want.logical_ok));
          if (out_word.widened_value !== want.widened_value)
            report_mismatch("widened_value", out_word.widened_value, want.widened_value);
          if (out_word.reg_is_64 !== want.reg_is_64)
            report_mismatch("reg_is_64", REG_W'(out_word.reg_is_64),
                            REG_W'(want.reg_is_64));
          if (want.addsub_negate) negated_seen <= negated_seen + 1;
          if (want.logical_ok) logical_seen <= logical_seen + 1;
        end
        results_seen <= results_seen + 1;
      end
      waiting <= encoding_q.size();
    end
  end

endmodule

// ===== verif/arm64_immediate_encodability_core_test.sv =====
// Top of the immediate encodability testbench: clock, reset, stimulus and
// the verdict. Prediction and comparison live in the checker beside the core.
module arm64_immediate_encodability_core_test;
  import a64imm_pkg::*;

  localparam int RANDOM_WORDS = 750;
  localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest correct run
  localparam int TAIL_CYCLES  = 8;       // pipeline is three deep

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int fail_count, waiting, results_seen, negated_seen, logical_seen;
  int cycle_count = 0;
  int directed_sent = 0;
  int random_sent = 0;
  // no idling on either side while this is set
  logic steady = 1'b0;

  always #5 clk = ~clk;

  arm64_immediate_encodability_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  arm64_immediate_encodability_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .fail_count   (fail_count),
    .waiting      (waiting),
    .results_seen (results_seen),
    .negated_seen (negated_seen),
    .logical_seen (logical_seen)
  );

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d result words outstanding",
             cycle_count, waiting);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver side: random back-pressure, about a third of the cycles.
  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 33);
  end

  function automatic in_word_t mk_word(logic [REG_W-1:0] raw, int sz, logic fl);
    in_word_t w;
    w.raw_value  = raw;
    w.size_bytes = sz[SIZE_W-1:0];
    w.is_float   = fl;
    return w;
  endfunction

  // Mostly legal sizes; now and then zero or above eight.
  function automatic int pick_size();
    if ($urandom_range(99) < 8) return ($urandom_range(1) == 0) ? 0 : $urandom_range(15, 9);
    return $urandom_range(8, 1);
  endfunction

  // Rotated run of ones in an element of 2..64 bits, replicated to 64 bits.
  function automatic logic [REG_W-1:0] bitmask_pattern();
    logic [REG_W-1:0] emask, elem, rot, rep;
    int e, ones, r;
    e     = 2 << $urandom_range(5);
    ones  = $urandom_range(e - 1, 1);
    r     = $urandom_range(e - 1);
    emask = (e == REG_W) ? '1 : ((64'd1 << e) - 64'd1);
    elem  = (64'd1 << ones) - 64'd1;
    rot   = (r == 0) ? elem : (((elem >> r) | (elem << (e - r))) & emask);
    rep   = '0;
    for (int off = 0; off < REG_W; off += e) rep = rep | (rot << off);
    return rep;
  endfunction

  function automatic in_word_t random_word();
    logic [REG_W-1:0] raw, k;
    int sz, kind;
    logic fl;
    kind = $urandom_range(9);
    sz   = pick_size();
    fl   = ($urandom_range(99) < 6);
    k    = REG_W'($urandom_range(12'hfff));
    if ($urandom_range(1)) k = k << IMM_BITS;
    case (kind)
      0, 1: begin
        raw = {$urandom, $urandom};
      end
      2, 3: begin
        // fits directly, maybe with junk above the size
        raw = k;
        if ($urandom_range(3) == 0) raw = raw | ({$urandom, $urandom} << 32);
      end
      4, 5: begin
        // negated immediates, mostly at W or X width
        raw = 64'd0 - k;
        if ($urandom_range(1)) sz = ($urandom_range(1) == 0) ? 4 : 8;
        if (k == 0) raw = 64'h8000_0000_0000_0000 >> ($urandom_range(1) * 32);
      end
      6, 7: begin
        raw = bitmask_pattern();
        if ($urandom_range(1)) sz = ($urandom_range(1) == 0) ? 4 : 8;
      end
      8: begin
        // one bit off a bitmask, or off a small immediate
        raw = ($urandom_range(1) ? bitmask_pattern() : k) ^ (64'd1 << $urandom_range(63));
      end
      default: begin
        // edges of the sign bit and of each width
        raw = (64'd1 << $urandom_range(63)) + $urandom_range(2) - 64'd1;
      end
    endcase
    return mk_word(raw, sz, fl);
  endfunction

  // Offer one word; the sender idles at random first unless steady.
  task automatic send_word(in_word_t w);
    while (!steady && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_directed(logic [REG_W-1:0] raw, int sz, logic fl);
    send_word(mk_word(raw, sz, fl));
    directed_sent++;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rejects, every width, direct vs negated, narrow sizes,
    // the most negative value and a few bitmask shapes.
    send_directed(64'hffff_ffff_ffff_ffff, 0, 1'b0);   // size zero rejects
    send_directed(64'h0000_0000_0000_0001, 15, 1'b0);  // size above eight
    send_directed(64'h0000_0000_0000_0001, 9, 1'b0);
    send_directed(64'h0000_0000_0000_0fff, 8, 1'b1);   // float rejects
    send_directed(64'h0000_0000_0000_0000, 8, 1'b0);   // zero: add/sub only
    send_directed(64'h0000_0000_0000_0fff, 8, 1'b0);
    send_directed(64'h0000_0000_0000_1000, 8, 1'b0);
    send_directed(64'h0000_0000_00ff_f000, 8, 1'b0);
    send_directed(64'h0000_0000_0000_1001, 8, 1'b0);   // neither form
    send_directed(64'hffff_ffff_ffff_ffff, 8, 1'b0);   // negates to one
    send_directed(64'hffff_ffff_ff00_1000, 8, 1'b0);   // negates to shifted max
    send_directed(64'h8000_0000_0000_0000, 8, 1'b0);   // never negated
    send_directed(64'h1234_5678_ffff_ffff, 4, 1'b0);   // W negate to one
    send_directed(64'h0000_0000_8000_0000, 4, 1'b0);
    send_directed(64'hffff_ffff_ffff_ffff, 1, 1'b0);   // narrow, zero-extended
    send_directed(64'hffff_ffff_ffff_ffff, 2, 1'b0);
    send_directed(64'hffff_ffff_ffff_ffff, 3, 1'b0);
    send_directed(64'hffff_ffff_ffff_ffff, 5, 1'b0);
    send_directed(64'hffff_ffff_ffff_f001, 6, 1'b0);
    send_directed(64'hffff_ffff_ffff_f001, 7, 1'b0);
    send_directed(64'h5555_5555_5555_5555, 8, 1'b0);   // two-bit element
    send_directed(64'h00ff_00ff_00ff_00ff, 8, 1'b0);
    send_directed(64'h0000_0000_0000_fffe, 4, 1'b0);
    send_directed(64'h0000_0000_ffff_ffff, 8, 1'b0);   // 64-bit run of 32 ones
    send_directed(64'h7fff_ffff_ffff_ffff, 8, 1'b0);

    // Random part, with a long stretch of full-rate traffic in the middle.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 300 && i < 450);
      send_word(random_word());
      random_sent++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain: let the checker's count settle, then wait for the last words.
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d result words from %0d directed and %0d random constants",
             results_seen, directed_sent, random_sent);
    $display("Seen: %0d negated add/sub encodings, %0d bitmask immediates, %0d mismatches",
             negated_seen, logical_seen, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/a64imm_pkg.sv
rtl/arm64_immediate_encodability_core.sv
rtl/a64imm_checker.sv
verif/arm64_immediate_encodability_checker.sv
verif/arm64_immediate_encodability_core_test.sv
